// ----- hw/rtl/svpm_pkg.sv -----
// Package for the voice pitch modulator: event and register codes, sequencer states,
// arithmetic constants and the operand bundle of the shared multiplier.
// No dependencies; every other file refers to it by scoped names.
package svpm_pkg;

    // Event codes carried by the op field.
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_NOTE_ON = 3'd1,
        OP_NOTE_OFF = 3'd2,
        OP_SUSTAIN = 3'd3,
        OP_BEND    = 3'd4,
        OP_EXPR    = 3'd5,
        OP_MAIN    = 3'd6
    } t_op;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SWEEP_DELAY  = 3'd0;
    localparam logic [2:0] CFG_SWEEP_AMOUNT = 3'd1;
    localparam logic [2:0] CFG_LFO_RATE     = 3'd2;
    localparam logic [2:0] CFG_LFO_AMOUNT   = 3'd3;
    localparam logic [2:0] CFG_LFO_SHAPE    = 3'd4;
    localparam logic [2:0] CFG_LFO_DELAY    = 3'd5;
    localparam logic [2:0] CFG_BEND_RANGE   = 3'd6;

    // LFO waveform codes.
    localparam logic [1:0] SHAPE_SINE  = 2'd0;
    localparam logic [1:0] SHAPE_SAW   = 2'd1;
    localparam logic [1:0] SHAPE_PULSE = 2'd2;

    // Phase is 4096 steps, the sine is sampled at 1024 points (256 per quarter).
    localparam int PHASE_W = 12;
    localparam logic [11:0] PHASE_HALF = 12'h800;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // Sine polynomial coefficients (Q15).
    localparam logic [24:0] K_SIN1 = 25'd51472;
    localparam logic [24:0] K_SIN3 = 25'd21024;
    localparam logic [24:0] K_SIN5 = 25'd2320;
    // Division by 5 for values below 2^15: multiply, then drop 17 bits.
    localparam logic [24:0] K_DIV5 = 25'd26215;
    // Pitch is summed in 1/204800 semitone; one semitone there is 204800 units.
    localparam logic [24:0] K_NOTE = 25'd204800;
    localparam logic [24:0] K_LFO  = 25'd800;
    // Division by 25 for values below 2^20: multiply, then drop 25 bits.
    localparam logic [24:0] K_DIV25 = 25'd1342178;
    localparam logic [42:0] PITCH_MAX = 43'd26009600;
    localparam logic [24:0] PITCH_HALF = 25'd400;
    localparam logic [15:0] SINE_ONE = 16'd32768;
    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [14:0] PITCH_Q8_MAX = 15'd32512;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE, ST_TK0, ST_TK1, ST_TK2, ST_LF0,
        ST_SN0, ST_SN1, ST_SN2, ST_SN3, ST_SN4, ST_SN5,
        ST_SN6, ST_SN7, ST_SN8, ST_SN9, ST_SN10, ST_SN11,
        ST_SAW0, ST_SAW1, ST_DV0, ST_DV1,
        ST_PT0, ST_PT1, ST_PT2, ST_PT3, ST_PT4, ST_PT5, ST_PT6, ST_PT7,
        ST_OUT
    } t_state;

    // Operand pair for the shared multiplier.
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

endpackage

// ----- hw/rtl/svpm_mul.sv -----
// Shared signed multiplier of the voice pitch modulator with a registered product.
// Depends on svpm_pkg for widths and the operand bundle.
module svpm_mul (
    input  logic                            i_clk,
    input  svpm_pkg::t_mul_req              i_req,
    output logic signed [svpm_pkg::PROD_W-1:0] o_prod
);

    logic signed [svpm_pkg::MUL_W-1:0] w_a;
    logic signed [svpm_pkg::MUL_W-1:0] w_b;

    assign w_a = $signed(i_req.a);
    assign w_b = $signed(i_req.b);

    // One product per cycle, registered before any use.
    always_ff @(posedge i_clk) begin
        o_prod <= w_a * w_b;
    end

endmodule

// ----- hw/rtl/synth_voice_pitch_modulator.sv -----
// Top level of the per-voice pitch and volume modulator: voice state, sequencer,
// configuration registers and output register. Uses svpm_pkg and svpm_mul.
// Non-tick events go straight to the pitch steps; a tick first updates the sweep and phase,
// then the LFO level by the sine, saw or pulse path unless the LFO is off or the shape unused.
// One item in flight; input is ready the cycle after the result loads.
// Reset (synchronous, active low) restores voice and register defaults.
module synth_voice_pitch_modulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_note_velocity,
    input  logic [13:0] i_bend_value,
    input  logic [6:0]  i_level_value,
    input  logic        i_pedal_down,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_pitch_q8,
    output logic [20:0] o_volume_product,
    output logic        o_release_now,
    output logic [6:0]  o_release_velocity,
    output logic        o_note_started,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    svpm_pkg::t_state r_state, n_state;
    svpm_pkg::t_mul_req w_req;
    logic signed [svpm_pkg::PROD_W-1:0] r_prod;

    // Configuration registers.
    logic [7:0] r_sweep_delay, r_lfo_rate, r_lfo_amount, r_lfo_delay;
    logic signed [7:0] r_sweep_amount;
    logic [1:0] r_lfo_shape;
    logic [4:0] r_bend_range;

    // Voice state.
    logic [31:0] r_tick_count;
    logic signed [31:0] r_sweep;
    logic signed [15:0] r_lfo;
    logic [6:0] r_note, r_vel, r_expr, r_main, r_pend_vel;
    logic [13:0] r_bend;
    logic r_pedal, r_pending;

    // Working registers of the sequencer.
    logic [svpm_pkg::PHASE_W-1:0] r_phase;
    logic r_neg;
    logic [19:0] r_ta;
    logic [15:0] r_tb, r_tc, r_td;
    logic signed [42:0] r_acc;
    logic [14:0] r_pitch;
    logic [20:0] r_vol;
    logic r_rel, r_started;
    logic [6:0] r_rel_vel;

    // Output register.
    logic r_o_valid;
    logic [14:0] r_o_pitch;
    logic [20:0] r_o_vol;
    logic r_o_rel, r_o_started;
    logic [6:0] r_o_rel_vel;

    logic w_in_xfer, w_out_load;
    logic w_sweep_on, w_lfo_on;
    logic [11:0] w_rate10;
    logic [9:0] w_range25;
    logic signed [14:0] w_bend_ofs;
    logic [9:0] w_idx;
    logic [8:0] w_x;
    logic [11:0] w_m;
    logic signed [32:0] w_sweep_sum;
    logic [27:0] w_s_raw;
    logic [15:0] w_s;
    logic [24:0] w_y;
    logic [24:0] w_y_rnd;
    logic [24:0] w_sine_m;
    logic [20:0] w_saw_m;
    logic [12:0] w_q;

    assign o_in_ready  = (r_state == svpm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == svpm_pkg::ST_OUT) && (!r_o_valid || i_out_ready);

    assign o_out_valid        = r_o_valid;
    assign o_pitch_q8         = r_o_pitch;
    assign o_volume_product   = r_o_vol;
    assign o_release_now      = r_o_rel;
    assign o_release_velocity = r_o_rel_vel;
    assign o_note_started     = r_o_started;

    svpm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (r_prod)
    );

    // Small helper values derived from registers.
    assign w_sweep_on = r_tick_count > {22'd0, r_sweep_delay, 2'b00};
    assign w_lfo_on   = r_tick_count > {22'd0, r_lfo_delay, 2'b00};
    assign w_rate10   = {1'b0, r_lfo_rate, 3'b000} + {3'b000, r_lfo_rate, 1'b0};
    assign w_range25  = {1'b0, r_bend_range, 4'd0} + {2'b00, r_bend_range, 3'd0}
                      + {5'd0, r_bend_range};
    assign w_bend_ofs = $signed({1'b0, r_bend}) - $signed({1'b0, svpm_pkg::BEND_CENTER});

    // Quarter-wave folding of the sine index.
    assign w_idx = r_phase[11:2];
    assign w_x   = w_idx[8] ? (9'd256 - {1'b0, w_idx[7:0]}) : {1'b0, w_idx[7:0]};
    assign w_m   = r_phase[11] ? (r_phase - svpm_pkg::PHASE_HALF)
                               : (svpm_pkg::PHASE_HALF - r_phase);

    // Saturating sweep sum.
    assign w_sweep_sum = r_sweep_amount[7]
                       ? ({r_sweep[31], r_sweep} - $signed({18'd0, r_prod[14:0]}))
                       : ({r_sweep[31], r_sweep} + $signed({18'd0, r_prod[14:0]}));

    // Sine magnitude clamp, rounding and scaling helpers.
    assign w_s_raw  = r_acc[42:15];
    assign w_s      = (w_s_raw > {12'd0, svpm_pkg::SINE_ONE}) ? svpm_pkg::SINE_ONE
                                                              : w_s_raw[15:0];
    assign w_sine_m = ({1'b0, r_prod[23:0]} + 25'd640) >> 8;
    assign w_saw_m  = ({1'b0, r_prod[19:0]} + 21'd40) >> 4;
    assign w_q      = r_prod[29:17];

    // Pitch clamp and half-up rounding ahead of the division by 25.
    assign w_y = r_acc[42] ? 25'd0
               : ((r_acc > $signed(svpm_pkg::PITCH_MAX)) ? svpm_pkg::PITCH_MAX[24:0]
                                                         : r_acc[24:0]);
    assign w_y_rnd = w_y + svpm_pkg::PITCH_HALF;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svpm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operands.
    always_comb begin
        n_state = r_state;
        w_req   = '0;
        unique case (r_state)
            svpm_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_op == svpm_pkg::OP_TICK) ? svpm_pkg::ST_TK0
                                                         : svpm_pkg::ST_PT0;
                end
            end
            svpm_pkg::ST_TK0: begin
                w_req.a = {{17{r_sweep_amount[7]}}, r_sweep_amount};
                w_req.b = {{17{r_sweep_amount[7]}}, r_sweep_amount};
                n_state = svpm_pkg::ST_TK1;
            end
            svpm_pkg::ST_TK1: begin
                w_req.a = {13'd0, w_rate10};
                w_req.b = {13'd0, r_tick_count[11:0]};
                n_state = svpm_pkg::ST_TK2;
            end
            svpm_pkg::ST_TK2: n_state = svpm_pkg::ST_LF0;
            svpm_pkg::ST_LF0: begin
                if (!w_lfo_on) begin
                    n_state = svpm_pkg::ST_PT0;
                end else begin
                    case (r_lfo_shape)
                        svpm_pkg::SHAPE_SINE:  n_state = svpm_pkg::ST_SN0;
                        svpm_pkg::SHAPE_SAW:   n_state = svpm_pkg::ST_SAW0;
                        svpm_pkg::SHAPE_PULSE: n_state = svpm_pkg::ST_DV0;
                        default:               n_state = svpm_pkg::ST_PT0;
                    endcase
                end
            end
            svpm_pkg::ST_SN0: begin
                w_req.a = {9'd0, r_ta[15:0]};
                w_req.b = {9'd0, r_ta[15:0]};
                n_state = svpm_pkg::ST_SN1;
            end
            svpm_pkg::ST_SN1: n_state = svpm_pkg::ST_SN2;
            svpm_pkg::ST_SN2: begin
                w_req.a = {9'd0, r_tb};
                w_req.b = {9'd0, r_ta[15:0]};
                n_state = svpm_pkg::ST_SN3;
            end
            svpm_pkg::ST_SN3: n_state = svpm_pkg::ST_SN4;
            svpm_pkg::ST_SN4: begin
                w_req.a = {9'd0, r_tc};
                w_req.b = {9'd0, r_tb};
                n_state = svpm_pkg::ST_SN5;
            end
            svpm_pkg::ST_SN5: begin
                w_req.a = {9'd0, r_ta[15:0]};
                w_req.b = svpm_pkg::K_SIN1;
                n_state = svpm_pkg::ST_SN6;
            end
            svpm_pkg::ST_SN6: begin
                w_req.a = {9'd0, r_tc};
                w_req.b = svpm_pkg::K_SIN3;
                n_state = svpm_pkg::ST_SN7;
            end
            svpm_pkg::ST_SN7: begin
                w_req.a = {9'd0, r_td};
                w_req.b = svpm_pkg::K_SIN5;
                n_state = svpm_pkg::ST_SN8;
            end
            svpm_pkg::ST_SN8: n_state = svpm_pkg::ST_SN9;
            svpm_pkg::ST_SN9: n_state = svpm_pkg::ST_SN10;
            svpm_pkg::ST_SN10: begin
                w_req.a = {9'd0, r_ta[15:0]};
                w_req.b = {17'd0, r_lfo_amount};
                n_state = svpm_pkg::ST_SN11;
            end
            svpm_pkg::ST_SN11: n_state = svpm_pkg::ST_DV0;
            svpm_pkg::ST_SAW0: begin
                w_req.a = {5'd0, r_ta};
                w_req.b = {17'd0, r_lfo_amount};
                n_state = svpm_pkg::ST_SAW1;
            end
            svpm_pkg::ST_SAW1: n_state = svpm_pkg::ST_DV0;
            svpm_pkg::ST_DV0: begin
                w_req.a = {5'd0, r_ta};
                w_req.b = svpm_pkg::K_DIV5;
                n_state = svpm_pkg::ST_DV1;
            end
            svpm_pkg::ST_DV1: n_state = svpm_pkg::ST_PT0;
            svpm_pkg::ST_PT0: begin
                w_req.a = {18'd0, r_note};
                w_req.b = svpm_pkg::K_NOTE;
                n_state = svpm_pkg::ST_PT1;
            end
            svpm_pkg::ST_PT1: begin
                w_req.a = {{10{w_bend_ofs[14]}}, w_bend_ofs};
                w_req.b = {15'd0, w_range25};
                n_state = svpm_pkg::ST_PT2;
            end
            svpm_pkg::ST_PT2: begin
                w_req.a = {{9{r_lfo[15]}}, r_lfo};
                w_req.b = svpm_pkg::K_LFO;
                n_state = svpm_pkg::ST_PT3;
            end
            svpm_pkg::ST_PT3: begin
                w_req.a = {18'd0, r_main};
                w_req.b = {18'd0, r_expr};
                n_state = svpm_pkg::ST_PT4;
            end
            svpm_pkg::ST_PT4: n_state = svpm_pkg::ST_PT5;
            svpm_pkg::ST_PT5: begin
                w_req.a = {9'd0, r_tb};
                w_req.b = {18'd0, r_vel};
                n_state = svpm_pkg::ST_PT6;
            end
            svpm_pkg::ST_PT6: begin
                w_req.a = {5'd0, r_ta};
                w_req.b = svpm_pkg::K_DIV25;
                n_state = svpm_pkg::ST_PT7;
            end
            svpm_pkg::ST_PT7: n_state = svpm_pkg::ST_OUT;
            svpm_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = svpm_pkg::ST_IDLE;
                end
            end
            default: n_state = svpm_pkg::ST_IDLE;
        endcase
    end

    // Voice state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_delay  <= '0;
            r_sweep_amount <= '0;
            r_lfo_rate     <= '0;
            r_lfo_amount   <= '0;
            r_lfo_shape    <= svpm_pkg::SHAPE_SINE;
            r_lfo_delay    <= '0;
            r_bend_range   <= 5'd2;
            r_tick_count   <= '0;
            r_sweep        <= '0;
            r_lfo          <= '0;
            r_note         <= '0;
            r_vel          <= 7'd127;
            r_bend         <= svpm_pkg::BEND_CENTER;
            r_expr         <= 7'd127;
            r_main         <= 7'd127;
            r_pedal        <= 1'b0;
            r_pending      <= 1'b0;
            r_pend_vel     <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            // Configuration transfer.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    svpm_pkg::CFG_SWEEP_DELAY:  r_sweep_delay  <= i_cfg_data;
                    svpm_pkg::CFG_SWEEP_AMOUNT: r_sweep_amount <= i_cfg_data;
                    svpm_pkg::CFG_LFO_RATE:     r_lfo_rate     <= i_cfg_data;
                    svpm_pkg::CFG_LFO_AMOUNT:   r_lfo_amount   <= i_cfg_data;
                    svpm_pkg::CFG_LFO_SHAPE:    r_lfo_shape    <= i_cfg_data[1:0];
                    svpm_pkg::CFG_LFO_DELAY:    r_lfo_delay    <= i_cfg_data;
                    svpm_pkg::CFG_BEND_RANGE:   r_bend_range   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            // Event updates take effect at the input transfer.
            if (w_in_xfer) begin
                unique case (i_op)
                    svpm_pkg::OP_TICK:    r_tick_count <= r_tick_count + 32'd1;
                    svpm_pkg::OP_NOTE_ON: begin
                        r_note <= i_note_number;
                        r_vel  <= i_note_velocity;
                    end
                    svpm_pkg::OP_NOTE_OFF: begin
                        if (r_pedal) begin
                            r_pending  <= 1'b1;
                            r_pend_vel <= i_note_velocity;
                        end
                    end
                    svpm_pkg::OP_SUSTAIN: begin
                        r_pedal <= i_pedal_down;
                        if (!i_pedal_down) begin
                            r_pending <= 1'b0;
                        end
                    end
                    svpm_pkg::OP_BEND: r_bend <= i_bend_value;
                    svpm_pkg::OP_EXPR: r_expr <= i_level_value;
                    svpm_pkg::OP_MAIN: r_main <= i_level_value;
                    default: ;
                endcase
            end

            // Sweep accumulates the signed square step with saturation.
            if (r_state == svpm_pkg::ST_TK1 && w_sweep_on) begin
                if (w_sweep_sum[32] != w_sweep_sum[31]) begin
                    r_sweep <= w_sweep_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_sweep <= w_sweep_sum[31:0];
                end
            end

            // New LFO level after the divide by five.
            if (r_state == svpm_pkg::ST_DV1) begin
                r_lfo <= r_neg ? -$signed({3'd0, w_q}) : $signed({3'd0, w_q});
            end

            // Output register: load a finished result, drop it once taken.
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_started <= (i_op == svpm_pkg::OP_NOTE_ON);
            if (i_op == svpm_pkg::OP_NOTE_OFF && !r_pedal) begin
                r_rel     <= 1'b1;
                r_rel_vel <= i_note_velocity;
            end else if (i_op == svpm_pkg::OP_SUSTAIN && !i_pedal_down && r_pending) begin
                r_rel     <= 1'b1;
                r_rel_vel <= r_pend_vel;
            end else begin
                r_rel     <= 1'b0;
                r_rel_vel <= '0;
            end
        end

        case (r_state)
            svpm_pkg::ST_TK2: r_phase <= r_prod[11:0];
            svpm_pkg::ST_LF0: begin
                r_neg <= (r_lfo_shape == svpm_pkg::SHAPE_SINE) ? r_phase[11] : !r_phase[11];
                case (r_lfo_shape)
                    svpm_pkg::SHAPE_SINE: r_ta <= {4'd0, w_x, 7'd0};
                    svpm_pkg::SHAPE_SAW:  r_ta <= {8'd0, w_m};
                    default:              r_ta <= {5'd0, r_lfo_amount, 7'd0} + 20'd2;
                endcase
            end
            svpm_pkg::ST_SN1:  r_tb  <= r_prod[30:15];
            svpm_pkg::ST_SN3:  r_tc  <= r_prod[30:15];
            svpm_pkg::ST_SN5:  r_td  <= r_prod[30:15];
            svpm_pkg::ST_SN6:  r_acc <= r_prod[42:0];
            svpm_pkg::ST_SN7:  r_acc <= r_acc - r_prod[42:0];
            svpm_pkg::ST_SN8:  r_acc <= r_acc + r_prod[42:0];
            svpm_pkg::ST_SN9:  r_ta  <= {4'd0, w_s};
            svpm_pkg::ST_SN11: r_ta  <= {5'd0, w_sine_m[14:0]};
            svpm_pkg::ST_SAW1: r_ta  <= {5'd0, w_saw_m[14:0]};
            svpm_pkg::ST_PT1:  r_acc <= r_prod[42:0];
            svpm_pkg::ST_PT2:  r_acc <= r_acc + r_prod[42:0];
            svpm_pkg::ST_PT3:  r_acc <= r_acc + r_prod[42:0];
            svpm_pkg::ST_PT4: begin
                r_acc <= r_acc + {{2{r_sweep[31]}}, r_sweep, 9'd0};
                r_tb  <= r_prod[15:0];
            end
            svpm_pkg::ST_PT5: r_ta    <= w_y_rnd[24:5];
            svpm_pkg::ST_PT6: r_vol   <= r_prod[20:0];
            svpm_pkg::ST_PT7: r_pitch <= r_prod[39:25];
            default: ;
        endcase

        if (w_out_load) begin
            r_o_pitch   <= r_pitch;
            r_o_vol     <= r_vol;
            r_o_rel     <= r_rel;
            r_o_rel_vel <= r_rel_vel;
            r_o_started <= r_started;
        end
    end

endmodule

// ----- hw/rtl/svpm_checker.sv -----
// Port-level checker for the voice pitch modulator, bound to the top level.
// Depends on svpm_pkg for the pitch ceiling.
module svpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [14:0] o_pitch_q8,
    input logic [20:0] o_volume_product,
    input logic        o_release_now,
    input logic [6:0]  o_release_velocity,
    input logic        o_note_started
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pitch_q8)
            && $stable(o_volume_product))
        else $error("result changed while stalled");

    // The block is busy right after taking an item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an input transfer");

    // No release velocity without a release.
    a_relvel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_release_now |-> o_release_velocity == 7'd0)
        else $error("release velocity without release");

    // A note-on never releases a note in the same result.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_note_started && o_release_now))
        else $error("note start and release together");

    // Pitch stays within the clamped range.
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pitch_q8 <= svpm_pkg::PITCH_Q8_MAX)
        else $error("pitch above range");

endmodule

bind synth_voice_pitch_modulator svpm_checker u_svpm_checker (.*);

// ----- tb/synth_voice_pitch_modulator_tb.sv -----
// Testbench for synth_voice_pitch_modulator: directed and random voice events with a
// cycle-free predictor of pitch, volume and sustain release. Depends on svpm_pkg and the RTL.
module synth_voice_pitch_modulator_tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    // One expected result.
    typedef struct {
        logic [14:0] pitch_q8;
        logic [20:0] volume_product;
        logic        release_now;
        logic [6:0]  release_velocity;
        logic        note_started;
    } t_voice_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [6:0]  i_note_number;
    logic [6:0]  i_note_velocity;
    logic [13:0] i_bend_value;
    logic [6:0]  i_level_value;
    logic        i_pedal_down;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [14:0] o_pitch_q8;
    logic [20:0] o_volume_product;
    logic        o_release_now;
    logic [6:0]  o_release_velocity;
    logic        o_note_started;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    synth_voice_pitch_modulator dut (.*);

    // Predictor copy of the registers and voice state.
    bit [7:0]  m_sweep_delay, m_sweep_amount, m_lfo_rate, m_lfo_amount, m_lfo_delay;
    bit [1:0]  m_lfo_shape;
    bit [4:0]  m_bend_range;
    bit [31:0] m_tick_count;
    int        m_sweep_offset, m_lfo_offset;
    bit [6:0]  m_note, m_velocity, m_expr, m_main, m_pending_vel;
    bit [13:0] m_bend;
    bit        m_pedal, m_pending;

    t_voice_result pending_results[$];
    int errors = 0;
    int burst_left = 0;
    int idle_count = 0;
    bit hold_req = 0;
    int hold_count = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Signed LFO scaling with the magnitude rounded half up.
    function automatic int lfo_scale(longint num, longint den, int depth);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag * depth * 256 + 5 * den) / (10 * den);
        return (num < 0) ? int'(-q) : int'(q);
    endfunction

    // Quarter-folded polynomial sine in Q15.
    function automatic longint sine_q15(bit [11:0] phase);
        longint unsigned idx, quad, r, x, t, t2, t3, t5, s;
        idx = phase >> 2;
        quad = (idx >> 8) & 3;
        r = idx & 255;
        x = (quad & 1) ? 256 - r : r;
        t = x * 128;
        t2 = (t * t) >> 15;
        t3 = (t2 * t) >> 15;
        t5 = (t3 * t2) >> 15;
        s = (64'd51472 * t + 64'd2320 * t5 - 64'd21024 * t3) >> 15;
        if (s > 32768) s = 32768;
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    // Advance the sweep and the LFO by one tick.
    task automatic tick_voice();
        longint v, ns;
        bit [31:0] ph32;
        bit [11:0] phase;
        m_tick_count = m_tick_count + 1;
        if (m_tick_count > 32'(m_sweep_delay) * 4) begin
            v = longint'($signed(m_sweep_amount));
            ns = longint'(m_sweep_offset) + ((v < 0) ? -(v * v) : v * v);
            if (ns > 64'sd2147483647) ns = 64'sd2147483647;
            if (ns < -64'sd2147483648) ns = -64'sd2147483648;
            m_sweep_offset = int'(ns);
        end
        if (m_tick_count > 32'(m_lfo_delay) * 4) begin
            ph32 = 32'(m_lfo_rate) * m_tick_count * 32'd10;
            phase = ph32[11:0];
            case (m_lfo_shape)
                svpm_pkg::SHAPE_SINE:
                    m_lfo_offset = lfo_scale(sine_q15(phase), 32768, m_lfo_amount);
                svpm_pkg::SHAPE_SAW:
                    m_lfo_offset = lfo_scale(2 * longint'(phase) - 4096, 4096,
                                             m_lfo_amount);
                svpm_pkg::SHAPE_PULSE:
                    m_lfo_offset = lfo_scale((phase < svpm_pkg::PHASE_HALF) ? -1 : 1, 1,
                                             m_lfo_amount);
                default: ;
            endcase
        end
    endtask

    // Apply one event to the voice and queue the result it produces.
    task automatic predict_voice(logic [2:0] op, logic [6:0] note, logic [6:0] vel,
                                 logic [13:0] bend, logic [6:0] level, logic pedal);
        t_voice_result res;
        longint x;
        res.release_now = 1'b0;
        res.release_velocity = 7'd0;
        res.note_started = 1'b0;
        case (op)
            svpm_pkg::OP_TICK: tick_voice();
            svpm_pkg::OP_NOTE_ON: begin
                m_note = note;
                m_velocity = vel;
                res.note_started = 1'b1;
            end
            svpm_pkg::OP_NOTE_OFF: begin
                if (m_pedal) begin
                    m_pending = 1'b1;
                    m_pending_vel = vel;
                end else begin
                    res.release_now = 1'b1;
                    res.release_velocity = vel;
                end
            end
            svpm_pkg::OP_SUSTAIN: begin
                m_pedal = pedal;
                if (!m_pedal && m_pending) begin
                    res.release_now = 1'b1;
                    res.release_velocity = m_pending_vel;
                    m_pending = 1'b0;
                end
            end
            svpm_pkg::OP_BEND: m_bend = bend;
            svpm_pkg::OP_EXPR: m_expr = level;
            svpm_pkg::OP_MAIN: m_main = level;
            default: ;
        endcase
        x = longint'(m_note) * 3276800 + (longint'(m_bend) - 8192) * longint'(m_bend_range) * 400
            + longint'(m_sweep_offset) * 8192 + longint'(m_lfo_offset) * 12800;
        if (x < 0) x = 0;
        if (x > 127 * 64'sd3276800) x = 127 * 64'sd3276800;
        res.pitch_q8 = 15'((x * 256 + 1638400) / 3276800);
        res.volume_product = 21'(m_main) * 21'(m_expr) * 21'(m_velocity);
        pending_results.push_back(res);
    endtask

    // Send one event; valid stays high while a burst goes on.
    task automatic send_event(logic [2:0] op, logic [6:0] note, logic [6:0] vel,
                              logic [13:0] bend, logic [6:0] level, logic pedal);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_note_number <= note;
        i_note_velocity <= vel;
        i_bend_value <= bend;
        i_level_value <= level;
        i_pedal_down <= pedal;
        do @(posedge i_clk); while (!o_in_ready);
        predict_voice(op, note, vel, bend, level, pedal);
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic send_random_event();
        logic [2:0] op;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) op = svpm_pkg::OP_TICK;
        else op = 3'($urandom_range(1, 7));
        send_event(op, 7'($urandom), 7'($urandom), 14'($urandom), 7'($urandom),
                   1'($urandom));
        pace_sender();
    endtask

    // Write one configuration register; the block is idle when this is called.
    task automatic write_reg(logic [2:0] index, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            svpm_pkg::CFG_SWEEP_DELAY:  m_sweep_delay = data;
            svpm_pkg::CFG_SWEEP_AMOUNT: m_sweep_amount = data;
            svpm_pkg::CFG_LFO_RATE:     m_lfo_rate = data;
            svpm_pkg::CFG_LFO_AMOUNT:   m_lfo_amount = data;
            svpm_pkg::CFG_LFO_SHAPE:    m_lfo_shape = data[1:0];
            svpm_pkg::CFG_LFO_DELAY:    m_lfo_delay = data;
            svpm_pkg::CFG_BEND_RANGE:   m_bend_range = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every expected result has come, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [7:0] sd, logic [7:0] sa, logic [7:0] lr,
                                  logic [7:0] la, logic [7:0] ls, logic [7:0] ld,
                                  logic [7:0] br);
        write_reg(svpm_pkg::CFG_SWEEP_DELAY, sd);
        write_reg(svpm_pkg::CFG_SWEEP_AMOUNT, sa);
        write_reg(svpm_pkg::CFG_LFO_RATE, lr);
        write_reg(svpm_pkg::CFG_LFO_AMOUNT, la);
        write_reg(svpm_pkg::CFG_LFO_SHAPE, ls);
        write_reg(svpm_pkg::CFG_LFO_DELAY, ld);
        write_reg(svpm_pkg::CFG_BEND_RANGE, br);
    endtask

    // Field extremes, every event, sustain release and pitch clamping.
    task automatic test_directed();
        send_event(svpm_pkg::OP_TICK, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_NOTE_ON, 7'd127, 7'd127, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_BEND, 7'd0, 7'd0, 14'd16383, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_NOTE_ON, 7'd0, 7'd0, 14'h3fff, 7'h7f, 1'b1);
        send_event(svpm_pkg::OP_BEND, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_EXPR, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_MAIN, 7'd127, 7'd127, 14'd0, 7'd127, 1'b0);
        send_event(svpm_pkg::OP_EXPR, 7'd0, 7'd0, 14'd0, 7'd127, 1'b0);
        send_event(svpm_pkg::OP_NOTE_ON, 7'd64, 7'd127, 14'd0, 7'd0, 1'b0);
        // Note-off without the pedal releases at once.
        send_event(svpm_pkg::OP_NOTE_OFF, 7'd0, 7'd99, 14'd0, 7'd0, 1'b0);
        // Release with nothing pending emits nothing.
        send_event(svpm_pkg::OP_SUSTAIN, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        // Held pedal records the latest note-off velocity.
        send_event(svpm_pkg::OP_SUSTAIN, 7'd0, 7'd0, 14'd0, 7'd0, 1'b1);
        send_event(svpm_pkg::OP_NOTE_OFF, 7'd0, 7'd17, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_NOTE_OFF, 7'd0, 7'd127, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_SUSTAIN, 7'd0, 7'd0, 14'd0, 7'd0, 1'b1);
        send_event(svpm_pkg::OP_SUSTAIN, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        // The unused event code only reports the state.
        send_event(OP_UNUSED, 7'h7f, 7'h7f, 14'h3fff, 7'h7f, 1'b1);
        send_event(svpm_pkg::OP_BEND, 7'd0, 7'd0, 14'd8192, 7'd0, 1'b0);
        drain();
        // Large bend range and a growing sweep drive the pitch into the upper clamp.
        write_all_regs(8'd0, 8'd127, 8'd255, 8'd255, svpm_pkg::SHAPE_PULSE, 8'd0, 8'd31);
        send_event(svpm_pkg::OP_BEND, 7'd0, 7'd0, 14'd16383, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_TICK, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_BEND, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        send_event(svpm_pkg::OP_TICK, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        drain();
        write_all_regs(8'd1, 8'h80, 8'd3, 8'd100, 8'hff, 8'd1, 8'd24);
        repeat (6) send_event(svpm_pkg::OP_TICK, 7'd0, 7'd0, 14'd0, 7'd0, 1'b0);
        drain();
    endtask

    // Hold the receiver off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        write_all_regs(8'd0, 8'd50, 8'd7, 8'd60, svpm_pkg::SHAPE_SINE, 8'd0, 8'd2);
        hold_req = 1'b1;
        repeat (30) send_event(3'($urandom_range(0, 6)), 7'($urandom), 7'($urandom),
                               14'($urandom), 7'($urandom), 1'($urandom));
        drain();
    endtask

    // Random phases under varying register settings, the extremes first.
    task automatic test_random();
        for (int p = 0; p < 8; p++) begin
            if (p == 0)
                write_all_regs(8'd255, 8'd127, 8'd255, 8'd255, svpm_pkg::SHAPE_SINE,
                               8'd255, 8'd24);
            else if (p == 1)
                write_all_regs(8'd0, 8'h80, 8'd0, 8'd0, svpm_pkg::SHAPE_SAW, 8'd0, 8'd0);
            else
                write_all_regs(8'($urandom_range(0, 6)), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)),
                               8'($urandom));
            // Well-formed phrases with random content, mixed with noise.
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_event(svpm_pkg::OP_NOTE_ON, 7'($urandom), 7'($urandom),
                               14'($urandom), 7'($urandom), 1'($urandom));
                    send_event(svpm_pkg::OP_SUSTAIN, 7'($urandom), 7'($urandom),
                               14'($urandom), 7'($urandom), 1'b1);
                    send_event(svpm_pkg::OP_NOTE_OFF, 7'($urandom), 7'($urandom),
                               14'($urandom), 7'($urandom), 1'($urandom));
                    send_event(svpm_pkg::OP_SUSTAIN, 7'($urandom), 7'($urandom),
                               14'($urandom), 7'($urandom), 1'b0);
                    n += 3;
                end else begin
                    send_random_event();
                end
            end
            drain();
        end
    endtask

    // Receiver: long hold-off on request, otherwise a changing stall pattern.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_count > 0) begin
            hold_count--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_count = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= (rx_cycle % 4 == 0);
            endcase
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_voice_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_pitch_q8 !== exp_res.pitch_q8) begin
                    $error("pitch_q8: expected %0d, got %0d", exp_res.pitch_q8, o_pitch_q8);
                    errors++;
                end
                if (o_volume_product !== exp_res.volume_product) begin
                    $error("volume_product: expected %0d, got %0d",
                           exp_res.volume_product, o_volume_product);
                    errors++;
                end
                if (o_release_now !== exp_res.release_now) begin
                    $error("release_now: expected %0d, got %0d",
                           exp_res.release_now, o_release_now);
                    errors++;
                end
                if (o_release_velocity !== exp_res.release_velocity) begin
                    $error("release_velocity: expected %0d, got %0d",
                           exp_res.release_velocity, o_release_velocity);
                    errors++;
                end
                if (o_note_started !== exp_res.note_started) begin
                    $error("note_started: expected %0d, got %0d",
                           exp_res.note_started, o_note_started);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("synth_voice_pitch_modulator_tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = svpm_pkg::OP_TICK;
        i_note_number = '0;
        i_note_velocity = '0;
        i_bend_value = '0;
        i_level_value = '0;
        i_pedal_down = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = svpm_pkg::CFG_SWEEP_DELAY;
        i_cfg_data = '0;
        m_sweep_delay = 0; m_sweep_amount = 0; m_lfo_rate = 0; m_lfo_amount = 0;
        m_lfo_shape = svpm_pkg::SHAPE_SINE; m_lfo_delay = 0; m_bend_range = 5'd2;
        m_tick_count = 0; m_sweep_offset = 0; m_lfo_offset = 0;
        m_note = 0; m_velocity = 7'd127; m_bend = svpm_pkg::BEND_CENTER;
        m_expr = 7'd127; m_main = 7'd127;
        m_pedal = 0; m_pending = 0; m_pending_vel = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        if (pending_results.size() != 0) begin
            $error("expectations left over at the end: %0d", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("synth_voice_pitch_modulator_tb: PASS");
        else
            $display("synth_voice_pitch_modulator_tb: FAIL");
        $finish;
    end

endmodule
